// ===== design/dtva_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtva_pkg
// Shared types and constants of the decimal token validate/average block.
// ----------------------------------------------------------------------------
package dtva_pkg;

  localparam int unsigned LIMIT_W = 17;
  localparam int unsigned MAG_W   = 17;
  localparam int unsigned VAL_W   = 18;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SUM_W   = 34;
  localparam int unsigned NUM_W   = SUM_W + 1;
  localparam int unsigned QUO_W   = 17;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned OUT_W   = 56;
  localparam int unsigned GROW_W  = 21;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;

  localparam logic [GROW_W-1:0]  MAG_MAX   = GROW_W'(131071);
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(100000);
  // min(MAX_COUNT, 65535) with MAX_COUNT = 65535
  localparam logic [CNT_W-1:0]   CNT_CAP   = CNT_W'(65535);
  localparam logic [STEP_W-1:0]  DIV_LAST  = STEP_W'(QUO_W - 1);

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  typedef struct packed {
    logic char_en;
    logic tok_end;
    logic rpt_start;
    logic div_en;
    logic rpt_finish;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/dtva_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtva_ctrl
// Handshake control, report sequencing and output valid.
// ----------------------------------------------------------------------------
module dtva_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_func,
  input  wire logic          in_last,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output dtva_pkg::cmd_t     cmd,
  input  wire dtva_pkg::sts_t sts
);

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       acc;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign acc        = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_RUN: begin
        in_tready     = in_func || !in_last || slot_free;
        cmd.char_en   = acc && !in_func;
        cmd.tok_end   = acc && !in_func && in_last;
        cmd.rpt_start = acc && in_func;
        if (acc && in_func) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.rpt_finish = 1'b1;
          state_nxt      = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    if (cmd.tok_end || cmd.rpt_finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_verdict_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tok_end |=> out_tvalid)
    else $error("verdict not presented");
  a_report_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rpt_start |=> (state_r == ST_DIV) && !in_tready)
    else $error("input taken during division");
  a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && sts.div_last |=> (state_r == ST_FIN))
    else $error("division did not finish");
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.tok_end, cmd.rpt_finish, cmd.rpt_start}))
    else $error("conflicting output loads");
`endif

endmodule

`default_nettype wire

// ===== design/dtva_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtva_dp
// Token parser, accumulator, restoring divider and output register.
// ----------------------------------------------------------------------------
module dtva_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [dtva_pkg::LIMIT_W-1:0]     cfg_wr_data,
  input  wire logic [7:0]                       ch,
  input  wire dtva_pkg::cmd_t                   cmd,
  output dtva_pkg::sts_t                        sts,
  output logic                                  out_kind,
  output logic [dtva_pkg::OUT_W-1:0]            out_data
);

  logic [dtva_pkg::LIMIT_W-1:0] limit_r;

  logic                         at_start_r, neg_r, point_r, digit_r, bad_r;
  logic [1:0]                   frac_r;
  logic [dtva_pkg::MAG_W-1:0]   mag_r;
  logic                         neg_nxt, point_nxt, digit_nxt, bad_nxt;
  logic [1:0]                   frac_nxt;
  logic [dtva_pkg::MAG_W-1:0]   mag_nxt;

  logic [dtva_pkg::SUM_W-1:0]   sum_r;
  logic [dtva_pkg::CNT_W-1:0]   cnt_r;

  logic                         is_digit;
  logic [3:0]                   dig;
  logic [dtva_pkg::GROW_W-1:0]  grow;
  logic                         ok;
  logic [dtva_pkg::VAL_W-1:0]   val;
  logic                         do_acc;
  logic [dtva_pkg::CNT_W-1:0]   cnt_nxt;

  logic [dtva_pkg::SUM_W-1:0]   sum_abs;
  logic [dtva_pkg::NUM_W-1:0]   num;
  logic [dtva_pkg::QUO_W-1:0]   rem_r, quo_r, dvs_r;
  logic                         rneg_r;
  logic [dtva_pkg::STEP_W-1:0]  step_r;
  logic [dtva_pkg::QUO_W:0]     trial;
  logic                         qbit;

  logic                         o_kind_r, o_legal_r, o_def_r;
  logic [dtva_pkg::VAL_W-1:0]   o_value_r, o_avg_r;
  logic [dtva_pkg::CNT_W-1:0]   o_count_r;

  // character step
  assign is_digit = (ch >= dtva_pkg::CH_ZERO) && (ch <= dtva_pkg::CH_NINE);
  assign dig      = 4'(ch - dtva_pkg::CH_ZERO);

  always_comb begin
    neg_nxt   = neg_r;
    point_nxt = point_r;
    digit_nxt = digit_r;
    bad_nxt   = bad_r;
    frac_nxt  = frac_r;
    mag_nxt   = mag_r;
    grow      = '0;
    priority if (ch == dtva_pkg::CH_MINUS && at_start_r) begin
      neg_nxt = 1'b1;
    end else if (ch == dtva_pkg::CH_POINT && !point_r) begin
      point_nxt = 1'b1;
    end else if (is_digit) begin
      digit_nxt = 1'b1;
      if (point_r && frac_r >= 2'd2) begin
        bad_nxt = 1'b1;
      end else begin
        if (point_r) begin
          frac_nxt = frac_r + 2'd1;
          grow = dtva_pkg::GROW_W'(mag_r) + ((frac_r == 2'd0) ?
                 dtva_pkg::GROW_W'(dig) * dtva_pkg::GROW_W'(10) :
                 dtva_pkg::GROW_W'(dig));
        end else begin
          grow = dtva_pkg::GROW_W'(mag_r) * dtva_pkg::GROW_W'(10) +
                 dtva_pkg::GROW_W'(dig) * dtva_pkg::GROW_W'(100);
        end
        if (grow > dtva_pkg::MAG_MAX) begin
          bad_nxt = 1'b1;
        end else begin
          mag_nxt = grow[dtva_pkg::MAG_W-1:0];
        end
      end
    end else begin
      bad_nxt = 1'b1;
    end
  end

  // verdict
  assign ok      = !bad_nxt && digit_nxt && (mag_nxt <= limit_r);
  assign val     = neg_nxt ? -{1'b0, mag_nxt} : {1'b0, mag_nxt};
  assign do_acc  = cmd.tok_end && ok && (cnt_r < dtva_pkg::CNT_CAP);
  assign cnt_nxt = do_acc ? cnt_r + 1'b1 : cnt_r;

  // report division: q = (2|sum| + n) / (2n), q < 2^17
  assign sum_abs = sum_r[dtva_pkg::SUM_W-1] ? -sum_r : sum_r;
  assign num     = {sum_abs, 1'b0} + dtva_pkg::NUM_W'(cnt_r);
  assign trial   = {rem_r, quo_r[dtva_pkg::QUO_W-1]};
  assign qbit    = trial >= {1'b0, dvs_r};
  assign sts.div_last = (step_r == dtva_pkg::DIV_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= dtva_pkg::LIMIT_RST;
      at_start_r <= 1'b1;
      neg_r      <= 1'b0;
      point_r    <= 1'b0;
      digit_r    <= 1'b0;
      bad_r      <= 1'b0;
      frac_r     <= '0;
      mag_r      <= '0;
      sum_r      <= '0;
      cnt_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (cmd.tok_end) begin
        at_start_r <= 1'b1;
        neg_r      <= 1'b0;
        point_r    <= 1'b0;
        digit_r    <= 1'b0;
        bad_r      <= 1'b0;
        frac_r     <= '0;
        mag_r      <= '0;
      end else if (cmd.char_en) begin
        at_start_r <= 1'b0;
        neg_r      <= neg_nxt;
        point_r    <= point_nxt;
        digit_r    <= digit_nxt;
        bad_r      <= bad_nxt;
        frac_r     <= frac_nxt;
        mag_r      <= mag_nxt;
      end
      if (do_acc) begin
        sum_r <= sum_r + {{(dtva_pkg::SUM_W - dtva_pkg::VAL_W){val[dtva_pkg::VAL_W-1]}}, val};
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rpt_start) begin
      rem_r  <= num[dtva_pkg::NUM_W-2:dtva_pkg::QUO_W];
      quo_r  <= num[dtva_pkg::QUO_W-1:0];
      dvs_r  <= {cnt_r, 1'b0};
      rneg_r <= sum_r[dtva_pkg::SUM_W-1];
      step_r <= '0;
    end else if (cmd.div_en) begin
      rem_r  <= qbit ? dtva_pkg::QUO_W'(trial - {1'b0, dvs_r}) :
                       trial[dtva_pkg::QUO_W-1:0];
      quo_r  <= {quo_r[dtva_pkg::QUO_W-2:0], qbit};
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tok_end) begin
      o_kind_r  <= dtva_pkg::KIND_VERDICT;
      o_legal_r <= ok;
      o_value_r <= ok ? val : '0;
      o_count_r <= cnt_nxt;
      o_avg_r   <= '0;
      o_def_r   <= 1'b0;
    end else if (cmd.rpt_finish) begin
      o_kind_r  <= dtva_pkg::KIND_REPORT;
      o_legal_r <= 1'b0;
      o_value_r <= '0;
      o_count_r <= cnt_r;
      if (cnt_r == '0) begin
        o_avg_r <= '0;
        o_def_r <= 1'b0;
      end else begin
        o_avg_r <= rneg_r ? -{1'b0, quo_r} : {1'b0, quo_r};
        o_def_r <= 1'b1;
      end
    end
  end

  assign out_kind = o_kind_r;
  assign out_data = {2'b00, o_def_r, o_avg_r, o_count_r, o_value_r, o_legal_r};

endmodule

`default_nettype wire

// ===== design/decimal_token_validate_average_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_token_validate_average_core
// Decimal token checker with running average of the legal values.
// ----------------------------------------------------------------------------
// Input stream: one transaction per token character (in_tuser = 0, char in
// in_tdata[7:0], in_tlast on the last character) or a report request
// (in_tuser = 1). Output stream: out_tuser = 0 for a token verdict, 1 for a
// report with the legal count and the rounded average in hundredths.
// Characters are taken one per cycle, but a token-ending character waits for
// a free output register. A verdict appears on the output in the cycle after
// the token's last character is accepted. A report runs a restoring divider
// at one quotient bit per cycle to form the 17-bit quotient, then waits for
// a free output register to present it; no input is taken in that time.
// cfg_wr_en/cfg_wr_data set the magnitude limit; write only when idle.
// Reset (rst_n low, synchronous) clears the sum, count and partial token and
// sets the limit to 100000 (1000.00).
// If out_tready is held low the output register holds its transaction; plain
// characters are still accepted, while a token-ending character or a finished
// report waits until the output register is free.
// ----------------------------------------------------------------------------
module decimal_token_validate_average_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [16:0] cfg_wr_data,  // abs_limit_hundredths
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] ch
  input  wire logic        in_tuser,     // [0] func
  input  wire logic        in_tlast,     // token_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,    // [0] legal, [18:1] value_hundredths,
                                         // [34:19] legal_count,
                                         // [52:35] average_hundredths,
                                         // [53] average_defined, [55:54] zero
  output logic             out_tuser     // [0] kind
);

  dtva_pkg::cmd_t cmd;
  dtva_pkg::sts_t sts;

  dtva_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_tuser),
    .in_last    (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  dtva_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ch          (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_kind    (out_tuser),
    .out_data    (out_tdata)
  );

endmodule

`default_nettype wire
